@@ design/atrp_pkg.sv @@
// Shared types, widths and constants of the accelerometer tilt/roll/pitch block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package atrp_pkg;

	localparam int AXW      = 20;   // raw axis code
	localparam int FSW      = 14;   // full-scale register
	localparam int UGW      = 24;   // micro-g result
	localparam int PRODW    = 34;   // |code| * full scale
	localparam int NUMW     = 44;   // |code| * full scale * 1000 + half divisor
	localparam int QW       = 25;   // quotient before saturation
	localparam int SQW      = 48;   // sum of two squares
	localparam int MAGW     = 24;   // magnitude
	localparam int SQRT_BITS = 24;  // one result bit per root stage
	localparam int SC_LAT   = 3;    // scaler stages
	localparam int SQ_LAT   = 26;   // square, sum and root stages
	localparam int OPW      = 25;   // signed angle operand
	localparam int CW       = 38;   // CORDIC datapath
	localparam int ACCW     = 32;   // angle accumulator
	localparam int ANGW     = 16;   // angle out of the CORDIC unit
	localparam int ATAN_LEN = 24;

	localparam logic [NUMW-1:0] DIVISOR    = 44'd524287;
	localparam logic [NUMW-1:0] ROUND_HALF = 44'd262143;
	localparam logic [QW-1:0]   UG_POS_MAX = 25'd8388607;
	localparam logic [QW-1:0]   UG_NEG_MAX = 25'd8388608;
	localparam logic [FSW-1:0]  FS_RESET   = 14'd2048;
	localparam logic signed [ACCW-1:0] HALF_TURN = 32'sd1179648000;

	typedef logic signed [UGW-1:0] ug_t;

	typedef struct packed {
		ug_t x;
		ug_t y;
		ug_t z;
	} axes_t;

	typedef struct packed {
		logic                    zero;
		logic signed [14:0]      pitch;
		logic signed [15:0]      roll;
		logic        [14:0]      tilt;
		axes_t                   ax;
	} res_t;

	// atan(2^-i) in 1/65536 of a hundredth of a degree
	function automatic logic [ACCW-1:0] atan_lut(input int unsigned idx);
		logic [ACCW-1:0] v;
		case (idx)
			0:  v = 32'd294912000;
			1:  v = 32'd174096719;
			2:  v = 32'd91987925;
			3:  v = 32'd46694507;
			4:  v = 32'd23437865;
			5:  v = 32'd11730358;
			6:  v = 32'd5866610;
			7:  v = 32'd2933484;
			8:  v = 32'd1466764;
			9:  v = 32'd733385;
			10: v = 32'd366693;
			11: v = 32'd183346;
			12: v = 32'd91673;
			13: v = 32'd45837;
			14: v = 32'd22918;
			15: v = 32'd11459;
			16: v = 32'd5730;
			17: v = 32'd2865;
			18: v = 32'd1432;
			19: v = 32'd716;
			20: v = 32'd358;
			21: v = 32'd179;
			22: v = 32'd90;
			23: v = 32'd45;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ design/atrp_scale.sv @@
// One axis: raw two's complement code to rounded, saturated micro-g, three stages.
// Depends on atrp_pkg.
`timescale 1ns / 1ps

module atrp_scale (
	input  logic                        clk,
	input  logic                        en,
	input  logic [atrp_pkg::AXW-1:0]    code,
	input  logic [atrp_pkg::FSW-1:0]    fs,
	output atrp_pkg::ug_t               ug
);

	logic [atrp_pkg::AXW-1:0]   absv;
	logic                       neg_s1, neg_s2;
	logic [atrp_pkg::PRODW-1:0] p_s1;
	logic [atrp_pkg::NUMW-1:0]  a, n, est, n_s2, r;
	logic [atrp_pkg::QW-1:0]    q1_s2, q, qs;
	atrp_pkg::ug_t              ug_s3;

	assign absv = code[atrp_pkg::AXW-1] ? (~code + 1'b1) : code;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= code[atrp_pkg::AXW-1];
			p_s1   <= atrp_pkg::PRODW'(absv) * atrp_pkg::PRODW'(fs);
		end
	end

	// times 1000 = 1024 - 16 - 8; divide by 2^19-1 as a geometric series in 2^-19
	always_comb begin
		a   = (atrp_pkg::NUMW'(p_s1) << 10) - (atrp_pkg::NUMW'(p_s1) << 4)
			- (atrp_pkg::NUMW'(p_s1) << 3);
		n   = a + atrp_pkg::ROUND_HALF;
		est = (n + (n >> 19) + (n >> 38)) >> 19;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2 <= neg_s1;
			n_s2   <= n;
			q1_s2  <= est[atrp_pkg::QW-1:0];
		end
	end

	// estimate is low by at most one
	always_comb begin
		r = n_s2 - (atrp_pkg::NUMW'(q1_s2) << 19) + atrp_pkg::NUMW'(q1_s2);
		q = q1_s2 + ((r >= atrp_pkg::DIVISOR) ? 25'd1 : 25'd0);
		if (neg_s2)
			qs = (q > atrp_pkg::UG_NEG_MAX) ? atrp_pkg::UG_NEG_MAX : q;
		else
			qs = (q > atrp_pkg::UG_POS_MAX) ? atrp_pkg::UG_POS_MAX : q;
	end

	always_ff @(posedge clk) begin
		if (en)
			ug_s3 <= neg_s2 ? -$signed(qs[atrp_pkg::UGW-1:0]) : $signed(qs[atrp_pkg::UGW-1:0]);
	end

	assign ug = ug_s3;

endmodule

@@ design/atrp_mag.sv @@
// Pipelined magnitudes sqrt(x^2+y^2) and sqrt(y^2+z^2), floor, one root bit per stage.
// Axes travel alongside. Depends on atrp_pkg.
`timescale 1ns / 1ps

module atrp_mag (
	input  logic                        clk,
	input  logic                        en,
	input  atrp_pkg::axes_t             ax_in,
	output logic [atrp_pkg::MAGW-1:0]   mag_xy,
	output logic [atrp_pkg::MAGW-1:0]   mag_yz,
	output atrp_pkg::axes_t             ax_out
);

	logic [atrp_pkg::SQW-1:0] sx_s1, sy_s1, sz_s1;
	logic [atrp_pkg::SQW-1:0] n_q [2][atrp_pkg::SQRT_BITS+1];
	logic [atrp_pkg::SQW-1:0] r_q [2][atrp_pkg::SQRT_BITS+1];
	atrp_pkg::axes_t          ax_q [atrp_pkg::SQ_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= atrp_pkg::SQW'(ax_in.x * ax_in.x);
			sy_s1 <= atrp_pkg::SQW'(ax_in.y * ax_in.y);
			sz_s1 <= atrp_pkg::SQW'(ax_in.z * ax_in.z);
			n_q[0][0] <= sx_s1 + sy_s1;
			n_q[1][0] <= sy_s1 + sz_s1;
			r_q[0][0] <= '0;
			r_q[1][0] <= '0;
		end
	end

	for (genvar k = 0; k < atrp_pkg::SQRT_BITS; k++) begin : g_root
		localparam logic [atrp_pkg::SQW-1:0] BIT = atrp_pkg::SQW'(1) << (46 - 2 * k);
		for (genvar l = 0; l < 2; l++) begin : g_lane
			always_ff @(posedge clk) begin
				if (en) begin
					if (n_q[l][k] >= r_q[l][k] + BIT) begin
						n_q[l][k+1] <= n_q[l][k] - (r_q[l][k] + BIT);
						r_q[l][k+1] <= (r_q[l][k] >> 1) + BIT;
					end else begin
						n_q[l][k+1] <= n_q[l][k];
						r_q[l][k+1] <= r_q[l][k] >> 1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_q[0] <= ax_in;
			for (int j = 1; j < atrp_pkg::SQ_LAT; j++)
				ax_q[j] <= ax_q[j-1];
		end
	end

	assign mag_xy = r_q[0][atrp_pkg::SQRT_BITS][atrp_pkg::MAGW-1:0];
	assign mag_yz = r_q[1][atrp_pkg::SQRT_BITS][atrp_pkg::MAGW-1:0];
	assign ax_out = ax_q[atrp_pkg::SQ_LAT-1];

endmodule

@@ design/atrp_cordic.sv @@
// Pipelined CORDIC vectoring: atan2(yy, xx) in hundredths of a degree, clamped.
// One stage per iteration plus a setup and a rounding stage. Depends on atrp_pkg.
`timescale 1ns / 1ps

module atrp_cordic #(
	parameter int STEPS = 16,
	parameter int LO    = -18000,
	parameter int HI    = 18000
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [atrp_pkg::OPW-1:0]     yy,
	input  logic signed [atrp_pkg::OPW-1:0]     xx,
	output logic signed [atrp_pkg::ANGW-1:0]    ang
);

	localparam logic signed [32:0] LO_V = 33'(LO);
	localparam logic signed [32:0] HI_V = 33'(HI);

	logic signed [atrp_pkg::CW-1:0]   x_q [STEPS+1];
	logic signed [atrp_pkg::CW-1:0]   y_q [STEPS+1];
	logic signed [atrp_pkg::ACCW-1:0] a_q [STEPS+1];
	logic                             z_q [STEPS+1];
	logic signed [atrp_pkg::CW-1:0]   xe, ye;
	logic signed [32:0]               rnd, clp;
	logic signed [atrp_pkg::ANGW-1:0] ang_q;

	// fold the left half plane onto the right one
	always_comb begin
		if (xx < 0) begin
			xe = -(atrp_pkg::CW'(xx) <<< 8);
			ye = -(atrp_pkg::CW'(yy) <<< 8);
		end else begin
			xe = atrp_pkg::CW'(xx) <<< 8;
			ye = atrp_pkg::CW'(yy) <<< 8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0] <= xe;
			y_q[0] <= ye;
			z_q[0] <= (yy == 0) && (xx == 0);
			if (xx < 0)
				a_q[0] <= (yy < 0) ? -atrp_pkg::HALF_TURN : atrp_pkg::HALF_TURN;
			else
				a_q[0] <= '0;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_iter
		localparam logic signed [atrp_pkg::ACCW-1:0] ATN = atrp_pkg::atan_lut(i);
		always_ff @(posedge clk) begin
			if (en) begin
				z_q[i+1] <= z_q[i];
				if (y_q[i] >= 0) begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					a_q[i+1] <= a_q[i] + ATN;
				end else begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					a_q[i+1] <= a_q[i] - ATN;
				end
			end
		end
	end

	always_comb begin
		rnd = (33'(a_q[STEPS]) + 33'sd32768) >>> 16;
		if (rnd < LO_V)
			clp = LO_V;
		else if (rnd > HI_V)
			clp = HI_V;
		else
			clp = rnd;
	end

	always_ff @(posedge clk) begin
		if (en)
			ang_q <= z_q[STEPS] ? '0 : clp[atrp_pkg::ANGW-1:0];
	end

	assign ang = ang_q;

endmodule

@@ design/accel_tilt_roll_pitch.sv @@
// Top level of the accelerometer tilt/roll/pitch block: handshake, valid line, output skid.
// Depends on atrp_pkg, atrp_scale, atrp_mag and atrp_cordic.
//
// Usage:
//   s_* carries one sample request per beat: three raw 20-bit two's complement axis codes.
//   m_* returns one result per sample, in order: the axes in micro-g, tilt, roll and
//   pitch in hundredths of a degree, and in m_tuser a flag for the all-zero vector.
//   cfg_* writes the full-scale register (milli-g at code 524287); write it only while
//   the pipeline is empty. cfg_ready is always high.
// From accept to m_tvalid a sample passes 3 scaler stages, 26 stages of squares and
//   bit-per-stage roots, CORDIC_STEPS + 2 CORDIC stages and the output register.
// Throughput is one sample per cycle while the skid register is free; the pipeline
// advances on a single enable.
// Reset clears every valid bit and loads a full scale of 2048 mg.
// When the receiver stalls, the output register holds its result and a second result
// drops into a skid register; only with the skid register full does s_tready fall and
// the whole pipeline hold. Nothing is lost or repeated.
`timescale 1ns / 1ps

module accel_tilt_roll_pitch #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [atrp_pkg::FSW-1:0]    cfg_data,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [63:0]                 s_tdata,   // x_code, y_code, z_code, zero pad
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [119:0]                m_tdata,   // x_ug, y_ug, z_ug, tilt, roll, pitch, pad
	output logic                        m_tuser    // zero_vector
);

	localparam int CLAT = CORDIC_STEPS + 2;
	localparam int LAT  = atrp_pkg::SC_LAT + atrp_pkg::SQ_LAT + CLAT;

	typedef struct packed {
		atrp_pkg::axes_t ax;
		logic            zero;
	} side_t;

	logic [atrp_pkg::FSW-1:0]          fs_q;
	logic                              en;
	logic [LAT-1:0]                    v_q;
	atrp_pkg::axes_t                   ax_sc, ax_mg;
	logic [atrp_pkg::MAGW-1:0]         mag_xy, mag_yz;
	side_t                             side_q [CLAT];
	logic signed [atrp_pkg::ANGW-1:0]  tilt_a, roll_a, pitch_a;
	atrp_pkg::res_t                    pipe_res, out_q, skid_q;
	logic                              out_v_q, skid_v_q;
	logic                              out_load;

	// full-scale register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fs_q <= atrp_pkg::FS_RESET;
		else if (cfg_valid)
			fs_q <= cfg_data;
	end

	// the pipeline moves as long as the skid register is free
	assign en       = !skid_v_q;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else if (en)
			v_q <= {v_q[LAT-2:0], s_tvalid};
	end

	atrp_scale u_scale_x (.clk(clk), .en(en), .code(s_tdata[19:0]),  .fs(fs_q), .ug(ax_sc.x));
	atrp_scale u_scale_y (.clk(clk), .en(en), .code(s_tdata[39:20]), .fs(fs_q), .ug(ax_sc.y));
	atrp_scale u_scale_z (.clk(clk), .en(en), .code(s_tdata[59:40]), .fs(fs_q), .ug(ax_sc.z));

	atrp_mag u_mag (
		.clk    (clk),
		.en     (en),
		.ax_in  (ax_sc),
		.mag_xy (mag_xy),
		.mag_yz (mag_yz),
		.ax_out (ax_mg)
	);

	// tilt = atan2(|xy|, z), roll = atan2(y, z), pitch = atan2(-x, |yz|)
	atrp_cordic #(.STEPS(CORDIC_STEPS), .LO(0), .HI(18000)) u_tilt (
		.clk (clk),
		.en  (en),
		.yy  ($signed({1'b0, mag_xy})),
		.xx  (atrp_pkg::OPW'(ax_mg.z)),
		.ang (tilt_a)
	);

	atrp_cordic #(.STEPS(CORDIC_STEPS), .LO(-18000), .HI(18000)) u_roll (
		.clk (clk),
		.en  (en),
		.yy  (atrp_pkg::OPW'(ax_mg.y)),
		.xx  (atrp_pkg::OPW'(ax_mg.z)),
		.ang (roll_a)
	);

	atrp_cordic #(.STEPS(CORDIC_STEPS), .LO(-9000), .HI(9000)) u_pitch (
		.clk (clk),
		.en  (en),
		.yy  (-atrp_pkg::OPW'(ax_mg.x)),
		.xx  ($signed({1'b0, mag_yz})),
		.ang (pitch_a)
	);

	// carry the axes and the zero flag beside the CORDIC stages
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0].ax   <= ax_mg;
			side_q[0].zero <= (ax_mg.x == 0) && (ax_mg.y == 0) && (ax_mg.z == 0);
			for (int j = 1; j < CLAT; j++)
				side_q[j] <= side_q[j-1];
		end
	end

	always_comb begin
		pipe_res.ax    = side_q[CLAT-1].ax;
		pipe_res.zero  = side_q[CLAT-1].zero;
		pipe_res.tilt  = tilt_a[14:0];
		pipe_res.roll  = roll_a;
		pipe_res.pitch = pitch_a[14:0];
	end

	// output register with a skid stage behind it
	assign out_load = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_load) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (out_load) begin
			out_v_q <= v_q[LAT-1];
		end else if (v_q[LAT-1]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_load)
				out_q <= skid_q;
		end else if (out_load) begin
			out_q <= pipe_res;
		end else begin
			skid_q <= pipe_res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.zero;
	assign m_tdata  = {2'b00, out_q.pitch, out_q.roll, out_q.tilt,
		out_q.ax.z, out_q.ax.y, out_q.ax.x};

	// a stalled result with another arriving must park it in the skid register
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !m_tready && !skid_v_q && v_q[LAT-1]) |=> skid_v_q)
		else $error("arriving result not parked in skid register");

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register full with output register empty");

	a_zero_angles: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (out_q.tilt == 0 && out_q.roll == 0 && out_q.pitch == 0))
		else $error("zero vector with nonzero angle");

	a_tilt_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_q.tilt <= 15'd18000))
		else $error("tilt out of range");

endmodule

@@ verif/tilt_checker.sv @@
// Checker for the accelerometer tilt/roll/pitch block: watches the sample, result and
// full-scale channels, predicts each result and compares it. Depends on atrp_pkg.
`timescale 1ns / 1ps

module tilt_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [13:0]  cfg_data,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [63:0]  s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [119:0] m_tdata,
	input  logic         m_tuser,
	output int           fail_count,
	output int           pending
);

	localparam int STEPS = 16;
	localparam longint HALF_TURN_L = 64'sd1179648000;

	typedef struct packed {
		logic        zero;
		logic [14:0] pitch;
		logic [15:0] roll;
		logic [14:0] tilt;
		logic [23:0] z;
		logic [23:0] y;
		logic [23:0] x;
	} angles_t;

	longint  scale_mg;
	angles_t expected_q[$];

	assign pending = expected_q.size();

	function automatic longint floor_shr(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -((-(v + 1)) >>> s) - 1;
	endfunction

	function automatic longint root_floor(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint vec_len(longint a, longint b);
		return root_floor(longint'(a * a) + longint'(b * b));
	endfunction

	// CORDIC vectoring angle in hundredths of a degree
	function automatic longint vector_angle(longint yy, longint xx, longint lo, longint hi);
		longint acc, r, dx, dy;
		acc = 0;
		if (yy == 0 && xx == 0)
			return 0;
		if (xx < 0) begin
			acc = (yy < 0) ? -HALF_TURN_L : HALF_TURN_L;
			xx = -xx;
			yy = -yy;
		end
		xx *= 256;
		yy *= 256;
		for (int i = 0; i < STEPS && i < 24; i++) begin
			dx = floor_shr(yy, i);
			dy = floor_shr(xx, i);
			if (yy >= 0) begin
				xx += dx;
				yy -= dy;
				acc += longint'(atrp_pkg::atan_lut(i));
			end else begin
				xx -= dx;
				yy += dy;
				acc -= longint'(atrp_pkg::atan_lut(i));
			end
		end
		r = floor_shr(acc + 32768, 16);
		if (r < lo) r = lo;
		if (r > hi) r = hi;
		return r;
	endfunction

	function automatic longint code_to_ug(logic [19:0] code);
		longint v, num, q;
		v = longint'(code);
		if (v >= 64'h80000)
			v -= 64'h100000;
		num = v * scale_mg * 1000;
		if (num >= 0)
			q = (2 * num + 524287) / (2 * 64'sd524287);
		else
			q = -((2 * (-num) + 524287) / (2 * 64'sd524287));
		if (q > 8388607) q = 8388607;
		if (q < -8388608) q = -8388608;
		return q;
	endfunction

	function automatic angles_t predict_angles(logic [63:0] d);
		angles_t a;
		longint x, y, z;
		x = code_to_ug(d[19:0]);
		y = code_to_ug(d[39:20]);
		z = code_to_ug(d[59:40]);
		a.x = x[23:0];
		a.y = y[23:0];
		a.z = z[23:0];
		a.zero = (x == 0 && y == 0 && z == 0);
		a.tilt = 15'(vector_angle(vec_len(x, y), z, 0, 18000));
		a.roll = 16'(vector_angle(y, z, -18000, 18000));
		a.pitch = 15'(vector_angle(-x, vec_len(y, z), -9000, 9000));
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		angles_t want, got;
		if (!arst_n) begin
			scale_mg <= 2048;
			fail_count <= 0;
			expected_q.delete();
		end else begin
			// results leave before new samples enter; a new sample is predicted with the scale as it stands
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata[117:0]};
				if (expected_q.size() == 0) begin
					$display("%0t: result with nothing expected: %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected x %h y %h z %h tilt %h roll %h pitch %h zero %b",
							$time, want.x, want.y, want.z, want.tilt, want.roll, want.pitch, want.zero);
						$display("%0t:          actual   x %h y %h z %h tilt %h roll %h pitch %h zero %b",
							$time, got.x, got.y, got.z, got.tilt, got.roll, got.pitch, got.zero);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_q.push_back(predict_angles(s_tdata));
			if (cfg_valid && cfg_ready)
				scale_mg <= longint'(cfg_data);
		end
	end
endmodule

@@ verif/testbench.sv @@
// Top of the tilt/roll/pitch testbench: clock, reset, sample and full-scale stimulus,
// receiver stalls and the verdict. Depends on accel_tilt_roll_pitch and tilt_checker.
`timescale 1ns / 1ps

module testbench;
	localparam int LATENCY = 48;
	localparam longint CYCLE_LIMIT = 600000;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         cfg_valid = 0;
	logic         cfg_ready;
	logic [13:0]  cfg_data = '0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [63:0]  s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [119:0] m_tdata;
	logic         m_tuser;
	int           fail_count, pending;
	longint       cycle_count = 0;
	bit           hold_off = 0;   // long receiver stall, requested by the stimulus

	always #5 clk = ~clk;

	accel_tilt_roll_pitch dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	tilt_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending(pending)
	);

	// Short gaps mostly, an occasional long one.
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Axis code biased toward the edges of the 20-bit two's complement range and toward zero.
	function automatic logic [19:0] axis_code();
		case ($urandom_range(0, 9))
			0: return 20'h7FFFF;
			1: return 20'h80000;
			2: return 20'h00000;
			3: return 20'(20'h00000 - $urandom_range(1, 8));
			4: return 20'($urandom_range(0, 8));
			default: return 20'($urandom());
		endcase
	endfunction

	task automatic send_sample(logic [19:0] x, logic [19:0] y, logic [19:0] z);
		s_tvalid <= 1;
		s_tdata <= {4'd0, z, y, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Pause the sample stream for a random gap; lower valid only if a gap follows.
	task automatic sample_gap(int n);
		if (n > 0) begin
			s_tvalid <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Write the full-scale register; call only with the pipeline empty.
	task automatic write_scale(logic [13:0] mg);
		cfg_valid <= 1;
		cfg_data <= mg;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
	endtask

	task automatic random_samples(int n, bit gaps);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_sample(20'($urandom()), 20'($urandom()), 20'($urandom()));
			else
				send_sample(axis_code(), axis_code(), axis_code());
			if (gaps)
				sample_gap(gap_length());
		end
	endtask

	// Receiver: random stalls, with stretches of none, and a long hold when asked.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				m_tready <= 0;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			n = gap_length();
			if (n > 0) begin
				m_tready <= 0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		logic [13:0] scales[6];
		scales = '{14'd2048, 14'd0, 14'd8192, 14'd16383, 14'd1, 14'd4000};
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: field extremes, zero vector, axis-aligned and opposite-sign cases.
		send_sample(20'h00000, 20'h00000, 20'h00000);
		send_sample(20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
		send_sample(20'h80000, 20'h80000, 20'h80000);
		send_sample(20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
		send_sample(20'h00000, 20'h00000, 20'h7FFFF);
		send_sample(20'h00000, 20'h00000, 20'h80000);
		send_sample(20'h7FFFF, 20'h00000, 20'h00000);
		send_sample(20'h80000, 20'h00000, 20'h00000);
		send_sample(20'h00000, 20'h7FFFF, 20'h00000);
		send_sample(20'h00000, 20'h80000, 20'h00000);
		send_sample(20'h00000, 20'h80000, 20'h80000);
		send_sample(20'h00000, 20'h7FFFF, 20'h80000);
		send_sample(20'h00001, 20'hFFFFF, 20'h00001);
		send_sample(20'h00000, 20'h00001, 20'hFFFFF);
		send_sample(20'h55555, 20'hAAAAA, 20'h12345);
		send_sample(20'hAAAAA, 20'h55555, 20'hEDCBA);
		drain();

		// Hold the receiver off long enough to fill the pipeline and stall the input.
		hold_off = 1;
		random_samples(150, 0);
		drain();

		// Random phases, one per full-scale setting, extremes among them.
		foreach (scales[k]) begin
			write_scale(scales[k]);
			random_samples(290, k % 2 == 0);
			drain();
		end

		if (fail_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule

@@ sim.f @@
design/atrp_pkg.sv
design/atrp_scale.sv
design/atrp_mag.sv
design/atrp_cordic.sv
design/accel_tilt_roll_pitch.sv
verif/tilt_checker.sv
verif/testbench.sv
